FILE: hdl/hue_blob_centroid_tracker_core_defines.svh
// Assertion macros for the hue blob centroid tracker checker.
// Depends on signals named clk and arst_n in the scope of use.
`ifndef HUE_BLOB_CENTROID_TRACKER_CORE_DEFINES_SVH
`define HUE_BLOB_CENTROID_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define HBCT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define HBCT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/hbct_pkg.sv
// Shared types, widths and constants of the hue blob centroid tracker.
// No dependencies.
`default_nettype none
package hbct_pkg;

	localparam int FRAME_WIDTH  = 1024;
	localparam int FRAME_HEIGHT = 1024;

	localparam int COORD_W = 10;
	localparam int HUE_W   = 9;
	localparam int CH_W    = 8;
	localparam int MARGIN_W = 8;
	localparam int COUNT_W = 21;
	localparam int SUM_W   = 31;
	localparam int WIN_W   = 11;
	localparam int BAND_W  = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 21;
	localparam int DIV_CNT_W  = $clog2(SUM_W);

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [CH_W-1:0] SAT_THRESH = 8'd216;
	localparam logic [CH_W-1:0] VAL_THRESH = 8'd64;
	localparam logic signed [BAND_W-1:0] DEG_FULL = 11'sd360;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HUE_CENTER  = 3'd0,
		REG_HUE_MARGIN  = 3'd1,
		REG_COLOR_MODE  = 3'd2,
		REG_MIN_COUNT   = 3'd3,
		REG_WIN_X_START = 3'd4,
		REG_WIN_X_END   = 3'd5,
		REG_WIN_Y_START = 3'd6,
		REG_WIN_Y_END   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic [HUE_W-1:0]   hue;
		logic [CH_W-1:0]    saturation;
		logic [CH_W-1:0]    brightness;
		logic               frame_end;
	} pix_t;

	typedef struct packed {
		logic               found;
		logic [COUNT_W-1:0] match_count;
		logic [COORD_W-1:0] center_x;
		logic [COORD_W-1:0] center_y;
	} res_t;

	typedef struct packed {
		logic [HUE_W-1:0]    hue_center;
		logic [MARGIN_W-1:0] hue_margin;
		logic                color_mode;
		logic [COUNT_W-1:0]  min_count;
		logic [WIN_W-1:0]    window_x_start;
		logic [WIN_W-1:0]    window_x_end;
		logic [WIN_W-1:0]    window_y_start;
		logic [WIN_W-1:0]    window_y_end;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		hue_center:     9'd0,
		hue_margin:     8'd20,
		color_mode:     1'b0,
		min_count:      21'd100,
		window_x_start: 11'd0,
		window_x_end:   11'd1024,
		window_y_start: 11'd0,
		window_y_end:   11'd1024
	};

	// Classified pixel as it sits in the queue.
	typedef struct packed {
		logic               hit;
		logic               last;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} entry_t;

	typedef struct packed {
		logic               start;
		logic [SUM_W-1:0]   dividend_x;
		logic [SUM_W-1:0]   dividend_y;
		logic [COUNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic [COORD_W-1:0] quo_x;
		logic [COORD_W-1:0] quo_y;
	} div_rsp_t;

endpackage
`default_nettype wire

FILE: hdl/hbct_stream_ifs.sv
// Valid/ready stream interfaces for pixels in and results out.
// Depends on hbct_pkg.
`default_nettype none
interface hbct_pix_if;
	logic valid;
	logic ready;
	hbct_pkg::pix_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface hbct_res_if;
	logic valid;
	logic ready;
	hbct_pkg::res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/hue_blob_centroid_tracker_core.sv
// Hue blob centroid tracker, top level. A frame_end pixel passes the input stage and the queue,
// then the back end runs the 31-step centroid divide and loads the output register.
// Throughput: one pixel per clock within a frame while the queue has room; at each frame
// end the back end pauses to divide while a 4-entry queue and the input stage take new pixels.
// Reset (arst_n low, asynchronous): registers to their defaults, sums cleared, queue empty.
// Depends on hbct_pkg, hbct_stream_ifs, hbct_front, hbct_fifo, hbct_back.
`default_nettype none
module hue_blob_centroid_tracker_core (
	input  wire logic clk,
	input  wire logic arst_n,
	hbct_pix_if.sink   pixel,
	hbct_res_if.source result,
	input  wire logic cfg_we,
	input  wire logic [hbct_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [hbct_pkg::CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers; the user must write them only while the block is idle; the block does not enforce this
	hbct_pkg::cfg_t cfg_q;

	// Front to queue, queue to back
	hbct_pkg::entry_t push_data, pop_data;
	logic push_valid, push_ready, pop_valid, pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= hbct_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (hbct_pkg::reg_idx_t'(cfg_index))
				hbct_pkg::REG_HUE_CENTER:  cfg_q.hue_center     <= cfg_data[hbct_pkg::HUE_W-1:0];
				hbct_pkg::REG_HUE_MARGIN:  cfg_q.hue_margin     <= cfg_data[hbct_pkg::MARGIN_W-1:0];
				hbct_pkg::REG_COLOR_MODE:  cfg_q.color_mode     <= cfg_data[0];
				hbct_pkg::REG_MIN_COUNT:   cfg_q.min_count      <= cfg_data[hbct_pkg::COUNT_W-1:0];
				hbct_pkg::REG_WIN_X_START: cfg_q.window_x_start <= cfg_data[hbct_pkg::WIN_W-1:0];
				hbct_pkg::REG_WIN_X_END:   cfg_q.window_x_end   <= cfg_data[hbct_pkg::WIN_W-1:0];
				hbct_pkg::REG_WIN_Y_START: cfg_q.window_y_start <= cfg_data[hbct_pkg::WIN_W-1:0];
				hbct_pkg::REG_WIN_Y_END:   cfg_q.window_y_end   <= cfg_data[hbct_pkg::WIN_W-1:0];
				default:                   cfg_q <= cfg_q;
			endcase
		end
	end

	// Front: input stage plus window / hue / saturation / value test
	hbct_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel      (pixel),
		.cfg        (cfg_q),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	// Queue absorbs pixels while the back end divides
	hbct_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	// Back: saturating sums, centroid divide, output register
	hbct_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_data  (pop_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.min_count (cfg_q.min_count),
		.result    (result)
	);

endmodule
`default_nettype wire

FILE: hdl/hbct_front.sv
// Front end: takes pixel transfers, classifies them against the window and hue band.
// Depends on hbct_pkg and hbct_stream_ifs.
`default_nettype none
module hbct_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	hbct_pix_if.sink            pixel,
	input  wire hbct_pkg::cfg_t cfg,
	output hbct_pkg::entry_t    push_data,
	output logic                push_valid,
	input  wire logic           push_ready
);

	logic signed [hbct_pkg::BAND_W-1:0] lo0, hi0, lo1, hi1, lo2, hi2, hue_s;
	logic swap_lo, swap_hi, band_in, band_out, hue_ok;
	logic in_win, in_frame, hit;
	logic [hbct_pkg::WIN_W-1:0] x_w, y_w;
	logic valid_s1;
	hbct_pkg::entry_t entry_s1;

	// Band bounds, swapped on wrap below 0 and at or past 360
	always_comb begin
		lo0 = $signed(hbct_pkg::BAND_W'(cfg.hue_center)) - $signed(hbct_pkg::BAND_W'(cfg.hue_margin));
		hi0 = $signed(hbct_pkg::BAND_W'(cfg.hue_center)) + $signed(hbct_pkg::BAND_W'(cfg.hue_margin));
		swap_lo = lo0 < 0;
		lo1 = swap_lo ? hi0 : lo0;
		hi1 = swap_lo ? lo0 + hbct_pkg::DEG_FULL : hi0;
		swap_hi = hi1 >= hbct_pkg::DEG_FULL;
		lo2 = swap_hi ? hi1 - hbct_pkg::DEG_FULL : lo1;
		hi2 = swap_hi ? lo1 : hi1;
		hue_s = $signed(hbct_pkg::BAND_W'(pixel.data.hue));
		band_in = (hue_s > lo2) && (hue_s < hi2);
		band_out = (hue_s < lo2) || (hue_s > hi2);
		hue_ok = cfg.color_mode ? band_in : band_out;
	end

	always_comb begin
		x_w = hbct_pkg::WIN_W'(pixel.data.pixel_x);
		y_w = hbct_pkg::WIN_W'(pixel.data.pixel_y);
		in_win = (x_w >= cfg.window_x_start) && (x_w < cfg.window_x_end) &&
			(y_w >= cfg.window_y_start) && (y_w < cfg.window_y_end);
		in_frame = (int'(pixel.data.pixel_x) < hbct_pkg::FRAME_WIDTH) &&
			(int'(pixel.data.pixel_y) < hbct_pkg::FRAME_HEIGHT);
		hit = in_win && in_frame && hue_ok &&
			(pixel.data.saturation > hbct_pkg::SAT_THRESH) &&
			(pixel.data.brightness > hbct_pkg::VAL_THRESH);
	end

	assign pixel.ready = !valid_s1 || push_ready;
	assign push_valid  = valid_s1;
	assign push_data   = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel.ready) begin
			valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel.valid && pixel.ready) begin
			entry_s1.hit  <= hit;
			entry_s1.last <= pixel.data.frame_end;
			entry_s1.x    <= pixel.data.pixel_x;
			entry_s1.y    <= pixel.data.pixel_y;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/hbct_fifo.sv
// Short queue of classified pixels between front and back end.
// Depends on hbct_pkg.
`default_nettype none
module hbct_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire hbct_pkg::entry_t push_data,
	input  wire logic             push_valid,
	output logic                  push_ready,
	output hbct_pkg::entry_t      pop_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready
);

	hbct_pkg::entry_t slot_q [hbct_pkg::QUEUE_DEPTH];
	logic [hbct_pkg::QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [hbct_pkg::QUEUE_AW:0]   fill_q;
	logic push, pop;

	assign push_ready = fill_q != (hbct_pkg::QUEUE_AW+1)'(hbct_pkg::QUEUE_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_data   = slot_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop  = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

FILE: hdl/hbct_div.sv
// Two-lane restoring divider, one quotient bit per cycle, shared divisor.
// Depends on hbct_pkg. Keeps only the low quotient bits.
`default_nettype none
module hbct_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  hbct_pkg::div_req_t req,
	output hbct_pkg::div_rsp_t rsp
);

	localparam int CW = hbct_pkg::COUNT_W;

	logic busy_q;
	logic [hbct_pkg::DIV_CNT_W-1:0] step_q;
	logic [CW-1:0] den_q, rem_x_q, rem_y_q;
	logic [hbct_pkg::SUM_W-1:0] num_x_q, num_y_q;
	logic [hbct_pkg::COORD_W-1:0] quo_x_q, quo_y_q;
	logic [CW:0] nx_x, nx_y;

	// Returns {quotient bit, new remainder}
	function automatic logic [CW:0] div_step(input logic [CW-1:0] rem, input logic nbit,
		input logic [CW-1:0] den);
		logic [CW:0]   sh;
		logic [CW+1:0] diff;
		sh = {rem, nbit};
		diff = {1'b0, sh} - {2'b00, den};
		if (diff[CW+1]) return {1'b0, sh[CW-1:0]};
		return {1'b1, diff[CW-1:0]};
	endfunction

	assign nx_x = div_step(rem_x_q, num_x_q[hbct_pkg::SUM_W-1], den_q);
	assign nx_y = div_step(rem_y_q, num_y_q[hbct_pkg::SUM_W-1], den_q);

	assign rsp.busy  = busy_q;
	assign rsp.quo_x = quo_x_q;
	assign rsp.quo_y = quo_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (!busy_q) begin
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end
		end else begin
			step_q <= step_q + 1'b1;
			if (step_q == hbct_pkg::DIV_CNT_W'(hbct_pkg::SUM_W - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && req.start) begin
			den_q   <= req.divisor;
			num_x_q <= req.dividend_x;
			num_y_q <= req.dividend_y;
			rem_x_q <= '0;
			rem_y_q <= '0;
		end else if (busy_q) begin
			num_x_q <= num_x_q << 1;
			num_y_q <= num_y_q << 1;
			rem_x_q <= nx_x[CW-1:0];
			rem_y_q <= nx_y[CW-1:0];
			quo_x_q <= {quo_x_q[hbct_pkg::COORD_W-2:0], nx_x[CW]};
			quo_y_q <= {quo_y_q[hbct_pkg::COORD_W-2:0], nx_y[CW]};
		end
	end

endmodule
`default_nettype wire

FILE: hdl/hbct_back.sv
// Back end: accumulates matches, runs the centroid divide at frame end, holds the result.
// Depends on hbct_pkg, hbct_stream_ifs and hbct_div.
`default_nettype none
module hbct_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire hbct_pkg::entry_t pop_data,
	input  wire logic             pop_valid,
	output logic                  pop_ready,
	input  wire logic [hbct_pkg::COUNT_W-1:0] min_count,
	hbct_res_if.source            result
);

	typedef enum logic {ST_ACC, ST_DIV} state_t;

	state_t state_q;
	logic [hbct_pkg::COUNT_W-1:0] count_acc_q, count_fin_q, count_nx, count_inc;
	logic [hbct_pkg::SUM_W-1:0]   x_sum_acc_q, y_sum_acc_q, x_nx, y_nx;
	logic [hbct_pkg::SUM_W:0]     x_wide, y_wide;
	logic found_q, res_valid_q, pop_fire, res_load;
	hbct_pkg::res_t res_q;
	hbct_pkg::div_req_t div_req;
	hbct_pkg::div_rsp_t div_rsp;

	assign pop_ready = state_q == ST_ACC;
	assign pop_fire  = pop_valid && pop_ready;
	// Divide done and the output register free (or emptying this cycle)
	assign res_load  = state_q == ST_DIV && !div_rsp.busy && (!res_valid_q || result.ready);

	// Saturating updates
	always_comb begin
		count_inc = (count_acc_q == hbct_pkg::COUNT_MAX) ? count_acc_q : count_acc_q + 1'b1;
		x_wide = {1'b0, x_sum_acc_q} + (hbct_pkg::SUM_W+1)'(pop_data.x);
		y_wide = {1'b0, y_sum_acc_q} + (hbct_pkg::SUM_W+1)'(pop_data.y);
		count_nx = pop_data.hit ? count_inc : count_acc_q;
		x_nx = !pop_data.hit ? x_sum_acc_q :
			(x_wide[hbct_pkg::SUM_W] ? hbct_pkg::SUM_MAX : x_wide[hbct_pkg::SUM_W-1:0]);
		y_nx = !pop_data.hit ? y_sum_acc_q :
			(y_wide[hbct_pkg::SUM_W] ? hbct_pkg::SUM_MAX : y_wide[hbct_pkg::SUM_W-1:0]);
	end

	always_comb begin
		div_req.start      = pop_fire && pop_data.last;
		div_req.dividend_x = x_nx;
		div_req.dividend_y = y_nx;
		div_req.divisor    = count_nx;
	end

	hbct_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			res_valid_q <= 1'b0;
			count_acc_q <= '0;
			x_sum_acc_q <= '0;
			y_sum_acc_q <= '0;
			count_fin_q <= '0;
			found_q     <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_load) res_valid_q <= 1'b1;
			else if (result.ready) res_valid_q <= 1'b0;
			case (state_q)
				ST_ACC: begin
					if (pop_fire) begin
						if (pop_data.last) begin
							count_acc_q <= '0;
							x_sum_acc_q <= '0;
							y_sum_acc_q <= '0;
							count_fin_q <= count_nx;
							found_q     <= count_nx > min_count;
							state_q     <= ST_DIV;
						end else begin
							count_acc_q <= count_nx;
							x_sum_acc_q <= x_nx;
							y_sum_acc_q <= y_nx;
						end
					end
				end
				ST_DIV: begin
					if (res_load) begin
						res_q.found       <= found_q;
						res_q.match_count <= count_fin_q;
						res_q.center_x    <= found_q ? div_rsp.quo_x : '0;
						res_q.center_y    <= found_q ? div_rsp.quo_y : '0;
						state_q           <= ST_ACC;
					end
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: hdl/hbct_checker.sv
// Port-level assertions for the tracker top level, bound in below.
// Depends on hbct_pkg and the assertion macro header.
`default_nettype none
`include "hue_blob_centroid_tracker_core_defines.svh"
module hbct_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pix_valid,
	input wire logic pix_ready,
	input wire logic pix_last,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire hbct_pkg::res_t res_data
);

	`HBCT_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data), "result dropped or changed while stalled")
	`HBCT_ASSERT_NOW(a_centre_zero, res_valid && !res_data.found, res_data.center_x == '0 && res_data.center_y == '0, "centroid not zero when not found")
	`HBCT_ASSERT_NOW(a_found_count, res_valid && res_data.match_count == '0, !res_data.found, "found with no matching pixels")
	`HBCT_ASSERT_NOW(a_no_early_res, $rose(res_valid), !$past(pix_valid && pix_ready && pix_last), "result directly after frame end transfer")

endmodule

bind hue_blob_centroid_tracker_core hbct_checker u_hbct_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pixel.valid),
	.pix_ready (pixel.ready),
	.pix_last  (pixel.data.frame_end),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_data  (result.data)
);
`default_nettype wire
